// ===== rtl/tscs_pkg.sv =====
// Shared types and constants of the text screen cursor and scroll core.
`default_nettype none

package tscs_pkg;

	localparam int CODE_W   = 9;
	localparam int ADDR_W   = 11;
	localparam int CURSOR_W = 11;
	localparam int CELL_W   = 16;
	localparam int ATTR_W   = 8;
	localparam int CHAR_W   = 8;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;
	localparam int M_PAD_W   = M_TDATA_W - CURSOR_W - CELL_W - 1;
	localparam int S_PAD_W   = S_TDATA_W - CODE_W - ADDR_W;

	localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'd256;
	localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;

	localparam logic MODE_PUT  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RDONE = 6'b000100,
		ST_COPY  = 6'b001000,
		ST_ZERO  = 6'b010000,
		ST_BLANK = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/text_screen_cursor_and_scroll_core.sv =====
// Text screen engine: character cell memory, cursor, newline/backspace and scroll-up.
//
// The block holds MEMORY_ROWS x COLUMNS character cells (attribute in bits 15..8,
// character in 7..0) in one synchronous RAM, plus a cursor kept as linear index,
// row and column. After reset a clearing pass writes zero to every cell, one cell
// a cycle; no request is taken until it ends, though attribute writes are taken at
// any time. For a read request or a put request that does not scroll, the accept
// cycle issues the RAM read or writes the character and updates the cursor, then
// the BLANK or RDONE state writes the trailing blank or captures the read data
// into the output register (that state repeats while an earlier result still
// waits). A put that reaches row SCROLL_ROW also copies rows 1..SCROLL_ROW-1 up
// one row through the single RAM port pair, one cell a cycle, then zeroes from
// the new cursor to the end of row SCROLL_ROW-1 (COLUMNS cells, as the new cursor
// always sits at the start of that row), then draws the blank. The output register
// lets the next request be accepted while a result waits.
// s_tdata: code [8:0], cell_address [19:9]; s_tuser: mode (0 put, 1 read).
// m_tdata: cursor_position [10:0], cell_data [26:11], scrolled [27].
`default_nettype none

module text_screen_cursor_and_scroll_core #(
	parameter int COLUMNS     = 80,
	parameter int SCROLL_ROW  = 24,
	parameter int MEMORY_ROWS = 25
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request channel
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [tscs_pkg::S_TDATA_W-1:0] s_tdata,   // code, cell_address
	input  wire logic                           s_tuser,   // mode
	// result channel
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [tscs_pkg::M_TDATA_W-1:0]      m_tdata,   // cursor_position, cell_data, scrolled
	// attribute register write
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tscs_pkg::ATTR_W-1:0]    cfg_data
);

	localparam int CELLS = MEMORY_ROWS * COLUMNS;
	localparam int LIMIT = SCROLL_ROW * COLUMNS;
	localparam int AMAX  = (CELLS > LIMIT) ? CELLS : LIMIT;
	localparam int XW0   = $clog2(AMAX + 1);
	localparam int XW    = (XW0 > tscs_pkg::ADDR_W) ? XW0 : tscs_pkg::ADDR_W;
	localparam int IW    = $clog2(CELLS);
	localparam int RW    = $clog2(SCROLL_ROW + 1);
	localparam int CLW   = $clog2(COLUMNS);

	localparam logic [XW-1:0]  CELLS_X  = XW'(CELLS);
	localparam logic [XW-1:0]  LIMIT_X  = XW'(LIMIT);
	localparam logic [XW-1:0]  COLS_X   = XW'(COLUMNS);
	localparam logic [CLW-1:0] LAST_COL = CLW'(COLUMNS - 1);
	localparam logic [RW-1:0]  SROW     = RW'(SCROLL_ROW);
	localparam logic [RW-1:0]  SROW_M1  = RW'(SCROLL_ROW - 1);

	// Request fields
	logic                          in_mode;
	logic [tscs_pkg::CODE_W-1:0]   in_code;
	logic [tscs_pkg::ADDR_W-1:0]   in_addr;
	logic                          s_acc;

	assign in_mode = s_tuser;
	assign in_code = s_tdata[tscs_pkg::CODE_W-1:0];
	assign in_addr = s_tdata[tscs_pkg::CODE_W +: tscs_pkg::ADDR_W];

	// Control state
	tscs_pkg::state_t              state_q;
	logic [XW-1:0]                 cursor_q;
	logic [RW-1:0]                 row_q;
	logic [CLW-1:0]                col_q;
	logic [XW-1:0]                 ptr_q;
	logic                          scr_q;
	logic [tscs_pkg::ATTR_W-1:0]   attr_q;
	logic                          m_valid_q;
	logic [tscs_pkg::M_TDATA_W-1:0] m_data_q;

	// RAM and its read pipeline
	logic [tscs_pkg::CELL_W-1:0]   mem [CELLS];
	logic [tscs_pkg::CELL_W-1:0]   rd_data_s1;
	logic                          rd_ok_s1;
	logic [XW-1:0]                 dst_s1;
	logic                          vld_s1;

	logic                          rd_en;
	logic [XW-1:0]                 rd_addr;
	logic                          wr_en;
	logic [XW-1:0]                 wr_addr;
	logic [tscs_pkg::CELL_W-1:0]   wr_data;

	// Next cursor for a put request
	logic [XW-1:0]                 nx_cur;
	logic [RW-1:0]                 nx_row;
	logic [CLW-1:0]                nx_col;
	logic                          nx_scroll;
	logic                          printable;
	logic                          out_free;
	logic [tscs_pkg::CELL_W-1:0]   rd_cell;

	assign s_tready  = (state_q == tscs_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_free  = !m_valid_q || m_tready;
	assign printable = (in_code != tscs_pkg::CODE_NEWLINE) &&
	                   (in_code != tscs_pkg::CODE_BACKSPACE);
	assign rd_cell   = rd_ok_s1 ? rd_data_s1 : '0;

	// Move the cursor by one put request; drop one row when it reaches the scroll row.
	always_comb begin
		nx_cur = cursor_q;
		nx_row = row_q;
		nx_col = col_q;
		if (in_code == tscs_pkg::CODE_NEWLINE) begin
			nx_col = '0;
			nx_row = row_q + RW'(1);
			nx_cur = cursor_q + COLS_X - XW'(col_q);
		end else if (in_code == tscs_pkg::CODE_BACKSPACE) begin
			if (cursor_q != '0) begin
				nx_cur = cursor_q - XW'(1);
				if (col_q == '0) begin
					nx_col = LAST_COL;
					nx_row = row_q - RW'(1);
				end else begin
					nx_col = col_q - CLW'(1);
				end
			end
		end else begin
			nx_cur = cursor_q + XW'(1);
			if (col_q == LAST_COL) begin
				nx_col = '0;
				nx_row = row_q + RW'(1);
			end else begin
				nx_col = col_q + CLW'(1);
			end
		end
		nx_scroll = (nx_row == SROW);
		if (nx_scroll) begin
			nx_row = SROW_M1;
			nx_cur = nx_cur - COLS_X;
		end
	end

	// RAM port selection per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = '0;
		unique case (state_q)
			tscs_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			tscs_pkg::ST_IDLE: begin
				rd_en   = s_acc && (in_mode == tscs_pkg::MODE_READ);
				rd_addr = XW'(in_addr);
				wr_en   = s_acc && (in_mode == tscs_pkg::MODE_PUT) && printable;
				wr_addr = cursor_q;
				wr_data = {attr_q, in_code[tscs_pkg::CHAR_W-1:0]};
			end
			tscs_pkg::ST_COPY: begin
				rd_en   = (ptr_q != LIMIT_X);
				wr_en   = vld_s1;
				wr_addr = dst_s1;
				wr_data = rd_cell;
			end
			tscs_pkg::ST_ZERO: begin
				wr_en = 1'b1;
			end
			tscs_pkg::ST_BLANK: begin
				wr_en   = 1'b1;
				wr_addr = cursor_q;
				wr_data = {attr_q, tscs_pkg::BLANK_CHAR};
			end
			default: begin
			end
		endcase
	end

	// Cell RAM: one write and one registered read a cycle; skip cells beyond memory.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr < CELLS_X)) begin
			mem[wr_addr[IW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr[IW-1:0]];
			rd_ok_s1   <= (rd_addr < CELLS_X);
			dst_s1     <= rd_addr - COLS_X;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (out_free && (state_q == tscs_pkg::ST_BLANK)) begin
			m_data_q <= {tscs_pkg::M_PAD_W'(0), scr_q, tscs_pkg::CELL_W'(0),
			             cursor_q[tscs_pkg::CURSOR_W-1:0]};
		end else if (out_free && (state_q == tscs_pkg::ST_RDONE)) begin
			m_data_q <= {tscs_pkg::M_PAD_W'(0), 1'b0, rd_cell,
			             cursor_q[tscs_pkg::CURSOR_W-1:0]};
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tscs_pkg::ST_CLEAR;
			cursor_q  <= '0;
			row_q     <= '0;
			col_q     <= '0;
			ptr_q     <= '0;
			scr_q     <= 1'b0;
			attr_q    <= tscs_pkg::ATTR_RESET;
			m_valid_q <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			vld_s1 <= (state_q == tscs_pkg::ST_COPY) && (ptr_q != LIMIT_X);
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				tscs_pkg::ST_CLEAR: begin
					ptr_q <= ptr_q + XW'(1);
					if (ptr_q == CELLS_X - XW'(1)) begin
						state_q <= tscs_pkg::ST_IDLE;
					end
				end
				tscs_pkg::ST_IDLE: begin
					if (s_acc) begin
						if (in_mode == tscs_pkg::MODE_READ) begin
							state_q <= tscs_pkg::ST_RDONE;
						end else begin
							cursor_q <= nx_cur;
							row_q    <= nx_row;
							col_q    <= nx_col;
							scr_q    <= nx_scroll;
							ptr_q    <= COLS_X;
							state_q  <= nx_scroll ? tscs_pkg::ST_COPY : tscs_pkg::ST_BLANK;
						end
					end
				end
				tscs_pkg::ST_COPY: begin
					// advance the source; the last copy lands while the source sits at the limit
					if (ptr_q != LIMIT_X) begin
						ptr_q <= ptr_q + XW'(1);
					end else begin
						ptr_q   <= cursor_q;
						state_q <= tscs_pkg::ST_ZERO;
					end
				end
				tscs_pkg::ST_ZERO: begin
					ptr_q <= ptr_q + XW'(1);
					if (ptr_q == LIMIT_X - XW'(1)) begin
						state_q <= tscs_pkg::ST_BLANK;
					end
				end
				tscs_pkg::ST_BLANK, tscs_pkg::ST_RDONE: begin
					// hold until the result register is free
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= tscs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tscs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Cursor stays above the scroll row between requests
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tscs_pkg::ST_IDLE) |-> (row_q < SROW))
		else $error("cursor row reached the scroll row outside a put");

	// Linear cursor agrees with row and column
	a_cursor_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tscs_pkg::ST_IDLE) |->
		(32'(cursor_q) == 32'(row_q) * COLUMNS + 32'(col_q)))
		else $error("cursor index out of step with row and column");

	// A copy write only follows a copy read
	a_copy_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ($past(state_q) == tscs_pkg::ST_COPY))
		else $error("copy write without a copy read");

	// A result is loaded only when the register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> ($stable(m_data_q) && m_valid_q))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
